/* rtl/cpc_pkg.sv */
// cpc_pkg: shared types and constants of the CORDIC coordinate converter.
// Holds the sequencer state and datapath op codes, the control word and the
// arctangent table; no dependencies.
package cpc_pkg;

    localparam int XW          = 64;   // x / y / remainder datapath width
    localparam int ZW          = 38;   // angle accumulator width, Q32 radians
    localparam int CNT_W       = 5;    // step counter, also CORDIC shift amount
    localparam int MUL_W       = 32;   // shared multiplier operand width
    localparam int GUARD_BITS  = 8;
    localparam int ANGLE_BITS  = 32;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'sd13493037705);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd6746518852);
    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(64'sd26986075410);
    localparam logic [XW-1:0]        TWO_PI_X  = 64'd26986075410;
    localparam logic [MUL_W-1:0]     GAIN_Q32  = 32'd2608131497;

    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_CART  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ROT,
        S_ABS,
        S_MUL_HI,
        S_MUL_LO,
        S_SUM,
        S_NEG,
        S_MOD,
        S_ZSIGN,
        S_ZWRAP,
        S_ZFOLD,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_PREP,
        OP_ROT,
        OP_ABS,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_SUM,
        OP_NEG,
        OP_MOD,
        OP_ZSIGN,
        OP_ZWRAP,
        OP_ZFOLD,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             cmd;
        logic [CNT_W-1:0] step;
    } t_ctrl;

    // atan(2^-i) in Q32 radians
    function automatic logic [31:0] atan_q32(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            5'd31: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

/* rtl/cpc_seq.sv */
// cpc_seq: sequencer of the converter; steps the datapath through load,
// angle reduction, CORDIC micro-rotations, gain scaling and output. Uses cpc_pkg.
module cpc_seq
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int FRACTION_BITS  = 16,
    parameter int ROTATION_STEPS = 18
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_cmd,
    input  logic  i_stall,
    output logic  o_stall,
    output logic  o_valid,
    output t_ctrl o_ctrl
);

    // angle input scaled to Q32: bounds the number of restoring mod-2pi steps
    localparam int ZSHIFT = ANGLE_BITS - FRACTION_BITS;
    localparam int MAG_W  = (DATA_WIDTH + ZSHIFT - 1 > XW - 1) ? XW - 1
                                                              : DATA_WIDTH + ZSHIFT - 1;
    localparam int KMAX   = (MAG_W > 35) ? MAG_W - 35 : 0;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROTATION_STEPS - 1);
    localparam logic [CNT_W-1:0] FIRST_K   = CNT_W'(KMAX);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cmd   <= CMD_TO_POLAR;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_state = (i_cmd == CMD_TO_CART) ? S_ABS : S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_ROT;
                n_cnt   = '0;
            end
            S_ROT: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = (r_cmd == CMD_TO_CART) ? S_FIN : S_ABS;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ABS:    n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_SUM;
            S_SUM:    n_state = S_NEG;
            S_NEG: begin
                if (r_cmd == CMD_TO_CART) begin
                    n_state = S_MOD;
                    n_cnt   = FIRST_K;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MOD: begin
                if (r_cnt == '0) begin
                    n_state = S_ZSIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ZSIGN: n_state = S_ZWRAP;
            S_ZWRAP: n_state = S_ZFOLD;
            S_ZFOLD: begin
                n_state = S_ROT;
                n_cnt   = '0;
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_valid     = (r_state == S_OUT);
        o_ctrl.cmd  = (r_state == S_IDLE) ? i_cmd : r_cmd;
        o_ctrl.step = r_cnt;
        unique case (r_state)
            S_IDLE:   o_ctrl.op = i_valid ? OP_LOAD : OP_HOLD;
            S_PREP:   o_ctrl.op = OP_PREP;
            S_ROT:    o_ctrl.op = OP_ROT;
            S_ABS:    o_ctrl.op = OP_ABS;
            S_MUL_HI: o_ctrl.op = OP_MUL_HI;
            S_MUL_LO: o_ctrl.op = OP_MUL_LO;
            S_SUM:    o_ctrl.op = OP_SUM;
            S_NEG:    o_ctrl.op = OP_NEG;
            S_MOD:    o_ctrl.op = OP_MOD;
            S_ZSIGN:  o_ctrl.op = OP_ZSIGN;
            S_ZWRAP:  o_ctrl.op = OP_ZWRAP;
            S_ZFOLD:  o_ctrl.op = OP_ZFOLD;
            S_FIN:    o_ctrl.op = OP_FIN;
            S_OUT:    o_ctrl.op = OP_HOLD;
            default:  o_ctrl.op = OP_HOLD;
        endcase
    end

endmodule

/* rtl/cpc_dp.sv */
// cpc_dp: datapath of the converter: x/y/z registers, CORDIC step unit,
// shared 32x32 gain multiplier, mod-2pi reducer, rounding and saturation. Uses cpc_pkg.
module cpc_dp
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  t_ctrl                        i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_a_in,
    input  logic signed [DATA_WIDTH-1:0] i_b_in,
    output logic signed [DATA_WIDTH-1:0] o_a_out,
    output logic signed [DATA_WIDTH-1:0] o_b_out
);

    localparam int ZSHIFT = ANGLE_BITS - FRACTION_BITS;
    localparam logic signed [XW-1:0] SAT_HI =
        $signed({{(XW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [XW-1:0] rnd_shift(input logic signed [XW-1:0] v,
                                                       input int s);
        logic signed [XW-1:0] sum;
        sum = v + $signed(XW'(1) << (s - 1));
        return sum >>> s;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    logic signed [XW-1:0] r_x, r_y;   // r_y holds the angle remainder while reducing
    logic signed [ZW-1:0] r_z;
    logic [XW-1:0]        r_prod, r_acc;
    logic                 r_mneg, r_zneg, r_zero;
    logic signed [DATA_WIDTH-1:0] r_a_out, r_b_out;

    logic signed [XW-1:0] a64, b64, ld_v, ld_mag, xs, ys, z64, p_sum;
    logic signed [ZW-1:0] at, rem;
    logic [XW-1:0]        dsh;
    logic [MUL_W-1:0]     mul_op;
    logic                 zpos;

    always_comb begin
        a64    = XW'(i_a_in);
        b64    = XW'(i_b_in);
        ld_v   = b64 <<< ZSHIFT;
        ld_mag = ld_v[XW-1] ? -ld_v : ld_v;
        xs     = r_x >>> i_ctrl.step;
        ys     = r_y >>> i_ctrl.step;
        at     = $signed(ZW'(atan_q32(i_ctrl.step)));
        zpos   = !r_z[ZW-1];
        dsh    = TWO_PI_X << i_ctrl.step;
        rem    = $signed(r_y[ZW-1:0]);
        z64    = XW'(r_z);
        mul_op = (i_ctrl.op == OP_MUL_HI) ? r_x[XW-1:MUL_W] : r_x[MUL_W-1:0];
        p_sum  = $signed(r_acc + (r_prod >> MUL_W));
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                r_x  <= a64 <<< GUARD_BITS;
                r_z  <= '0;
                if (i_ctrl.cmd == CMD_TO_CART) begin
                    r_y    <= ld_mag;
                    r_zneg <= ld_v[XW-1];
                    r_zero <= 1'b0;
                end else begin
                    r_y    <= b64 <<< GUARD_BITS;
                    r_zero <= (i_a_in == '0) && (i_b_in == '0);
                end
            end
            OP_PREP: begin
                // left half plane: mirror through the origin, start angle at +-pi
                if (r_x[XW-1]) begin
                    r_z <= r_y[XW-1] ? -PI_Z : PI_Z;
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
            end
            OP_ROT: begin
                if (i_ctrl.cmd == CMD_TO_CART) begin
                    if (zpos) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                end else begin
                    if (r_y[XW-1]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                end
            end
            OP_ABS: begin
                r_mneg <= r_x[XW-1];
                r_x    <= r_x[XW-1] ? -r_x : r_x;
                if (r_z > PI_Z) begin
                    r_z <= PI_Z;
                end else if (r_z < -PI_Z) begin
                    r_z <= -PI_Z;
                end
            end
            OP_MUL_HI: r_prod <= XW'(mul_op) * XW'(GAIN_Q32);
            OP_MUL_LO: begin
                r_acc  <= r_prod;
                r_prod <= XW'(mul_op) * XW'(GAIN_Q32);
            end
            OP_SUM: r_x <= p_sum;
            OP_NEG: begin
                if (r_mneg) begin
                    r_x <= -r_x;
                end
            end
            OP_MOD: begin
                // restoring reduction of |angle| by 2pi, one shifted divisor per step
                if ($unsigned(r_y) >= dsh) begin
                    r_y <= $signed($unsigned(r_y) - dsh);
                end
            end
            OP_ZSIGN: r_z <= r_zneg ? -rem : rem;
            OP_ZWRAP: begin
                if (r_z > PI_Z) begin
                    r_z <= r_z - TWO_PI_Z;
                end else if (r_z < -PI_Z) begin
                    r_z <= r_z + TWO_PI_Z;
                end
            end
            OP_ZFOLD: begin
                r_y <= '0;
                if (r_z > HALF_PI_Z) begin
                    r_z <= r_z - PI_Z;
                    r_x <= -r_x;
                end else if (r_z < -HALF_PI_Z) begin
                    r_z <= r_z + PI_Z;
                    r_x <= -r_x;
                end
            end
            OP_FIN: begin
                if (r_zero) begin
                    r_a_out <= '0;
                    r_b_out <= '0;
                end else begin
                    r_a_out <= sat(rnd_shift(r_x, GUARD_BITS));
                    if (i_ctrl.cmd == CMD_TO_CART) begin
                        r_b_out <= sat(rnd_shift(r_y, GUARD_BITS));
                    end else begin
                        r_b_out <= sat(rnd_shift(z64, ZSHIFT));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_a_out = r_a_out;
    assign o_b_out = r_b_out;

endmodule

/* rtl/cartesian_polar_converter_core.sv */
// Cartesian <-> polar converter, iterative CORDIC, one word in flight at a time.
// Cmd 0 runs half-plane mirror, micro-rotations, gain scaling and output; cmd 1 runs
// gain scaling, K+1 restoring mod-2pi steps (K set by the angle width in Q32, K=12 at
// defaults), wrap, fold, micro-rotations, output. One CORDIC micro-rotation per cycle.
// Synchronous active-low reset returns the sequencer to idle; no word is held.
module cartesian_polar_converter_core
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int FRACTION_BITS  = 16,
    parameter int ROTATION_STEPS = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_a_in,
    input  logic signed [DATA_WIDTH-1:0] i_b_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_a_out,
    output logic signed [DATA_WIDTH-1:0] o_b_out
);

    t_ctrl ctrl;

    cpc_seq #(
        .DATA_WIDTH     (DATA_WIDTH),
        .FRACTION_BITS  (FRACTION_BITS),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctrl  (ctrl)
    );

    cpc_dp #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_a_in  (i_a_in),
        .i_b_in  (i_b_in),
        .o_a_out (o_a_out),
        .o_b_out (o_b_out)
    );

endmodule

/* rtl/cpc_checker.sv */
// cpc_port_props: port-level assertions for cartesian_polar_converter_core,
// attached by the bind below; no package dependency.
module cpc_port_props #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [DATA_WIDTH-1:0] o_a_out,
    input logic [DATA_WIDTH-1:0] o_b_out
);

    // a stalled result word stays up and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_a_out) && $stable(o_b_out))
        else $error("result word dropped or changed while stalled");

    // one word in flight: accepting closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after accept");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result waits");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

endmodule

bind cartesian_polar_converter_core cpc_port_props #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cpc_port_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_a_out (o_a_out),
    .o_b_out (o_b_out)
);

/* verif/cpc_checker.sv */
// cpc_checker: watches both channels of the CORDIC coordinate converter, predicts
// each result word from the accepted input word and compares field by field.
// Depends on cpc_pkg for the command codes.
module cpc_checker
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int FRACTION_BITS  = 16,
    parameter int ROTATION_STEPS = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         in_cmd,
    input  logic signed [DATA_WIDTH-1:0] in_a,
    input  logic signed [DATA_WIDTH-1:0] in_b,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [DATA_WIDTH-1:0] out_a,
    input  logic signed [DATA_WIDTH-1:0] out_b,
    output int                           mismatches,
    output int                           outstanding,
    output int                           words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW         = DATA_WIDTH;
    localparam int GUARD      = 8;
    localparam int ZFRAC      = 32;
    localparam int STEPS_RUN  = (ROTATION_STEPS < 32) ? ROTATION_STEPS : 32;
    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint HALF_PI_Q32 = 64'sd6746518852;
    localparam longint TWO_PI_Q32  = 64'sd26986075410;
    localparam longint unsigned GAIN_K = 64'd2608131497;   // 1/K in Q0.32

    typedef struct packed {
        logic                 cmd;
        logic signed [DW-1:0] a_in;
        logic signed [DW-1:0] b_in;
        logic signed [DW-1:0] a_out;
        logic signed [DW-1:0] b_out;
    } t_conv_word;

    // atan(2^-i), Q32 radians
    longint atan_tab [32] = '{
        64'sd3373259426, 1991351318, 1052175346, 534100635,
        268086748, 134174063, 67103403, 33553749,
        16777131, 8388597, 4194303, 2097152,
        1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512,
        256, 128, 64, 32,
        16, 8, 4, 2
    };

    t_conv_word due_q[$];
    t_conv_word due;
    int         fail_count = 0;
    int         pass_count = 0;

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        words_checked = 0;
    end

    // sign-magnitude multiply by 1/K, floor of the magnitude product
    function automatic longint remove_gain(input longint v);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (v < 0) ? -v : v;
        prod = (mag >> 32) * GAIN_K + (((mag & 64'hFFFF_FFFF) * GAIN_K) >> 32);
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint round_off(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [DW-1:0] clip(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DW-1:0];
    endfunction

    function automatic void cordic_convert(
        input  logic                 cmd,
        input  logic signed [DW-1:0] a,
        input  logic signed [DW-1:0] b,
        output logic signed [DW-1:0] ra,
        output logic signed [DW-1:0] rb
    );
        longint x;
        longint y;
        longint z;
        longint t;
        z = 0;
        if (cmd == CMD_TO_POLAR) begin
            if (a == 0 && b == 0) begin
                ra = '0;
                rb = '0;
                return;
            end
            x = longint'(a) <<< GUARD;
            y = longint'(b) <<< GUARD;
            // left half plane: flip the vector, start the angle at +-pi
            if (x < 0) begin
                z = (y >= 0) ? PI_Q32 : -PI_Q32;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS_RUN; i++) begin
                if (y < 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_tab[i];
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_tab[i];
                end
                x = t;
            end
            if (z > PI_Q32) z = PI_Q32;
            if (z < -PI_Q32) z = -PI_Q32;
            ra = clip(round_off(remove_gain(x), GUARD));
            rb = clip(round_off(z, ZFRAC - FRACTION_BITS));
        end else begin
            x = remove_gain(longint'(a) <<< GUARD);
            y = 0;
            z = (longint'(b) <<< (ZFRAC - FRACTION_BITS)) % TWO_PI_Q32;
            if (z > PI_Q32) z = z - TWO_PI_Q32;
            if (z < -PI_Q32) z = z + TWO_PI_Q32;
            // beyond +-pi/2: turn by pi and negate the start vector
            if (z > HALF_PI_Q32) begin
                z = z - PI_Q32;
                x = -x;
            end else if (z < -HALF_PI_Q32) begin
                z = z + PI_Q32;
                x = -x;
            end
            for (int i = 0; i < STEPS_RUN; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_tab[i];
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_tab[i];
                end
                x = t;
            end
            ra = clip(round_off(x, GUARD));
            rb = clip(round_off(y, GUARD));
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                due.cmd  = in_cmd;
                due.a_in = in_a;
                due.b_in = in_b;
                cordic_convert(in_cmd, in_a, in_b, due.a_out, due.b_out);
                due_q = {due_q, due};
            end
            if (out_valid && !out_stall) begin
                if (due_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result word with nothing pending: a_out %0d b_out %0d",
                                 $time, out_a, out_b);
                    fail_count++;
                end else begin
                    due = due_q.pop_front();
                    if (out_a !== due.a_out || out_b !== due.b_out) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch cmd %0d in (%0d, %0d): ",
                                      "a_out %0d exp %0d, b_out %0d exp %0d"},
                                     $time, due.cmd, due.a_in, due.b_in,
                                     out_a, due.a_out, out_b, due.b_out);
                        fail_count++;
                    end
                    pass_count++;
                end
            end
        end
        mismatches    <= fail_count;
        words_checked <= pass_count;
        outstanding   <= due_q.size();
    end

endmodule

/* verif/tb_cartesian_polar_converter_core.sv */
// tb_cartesian_polar_converter_core: drives words into the CORDIC converter under
// random idling on both sides and a long output hold; cpc_checker does the checking.
// Depends on cpc_pkg, cpc_checker and the converter RTL.
module tb_cartesian_polar_converter_core
    import cpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int STEPS = 18;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_WORDS  = 600;
    localparam logic signed [DW-1:0] MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] MIN_V = 32'sh8000_0000;
    localparam int ONE         = 65536;     // 1.0 in Q16.16
    localparam int HALF_PI_Q16 = 102944;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_cmd;
    logic signed [DW-1:0] i_a_in;
    logic signed [DW-1:0] i_b_in;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [DW-1:0] o_a_out;
    logic signed [DW-1:0] o_b_out;

    int mismatches;
    int outstanding;
    int words_checked;
    int send_idle_pct  = 15;
    int recv_stall_pct = 64;
    int n_to_polar     = 0;
    int n_to_cart      = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;

    cartesian_polar_converter_core #(
        .DATA_WIDTH    (DW),
        .FRACTION_BITS (FB),
        .ROTATION_STEPS(STEPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd  (i_cmd),
        .i_a_in (i_a_in),
        .i_b_in (i_b_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_a_out(o_a_out),
        .o_b_out(o_b_out)
    );

    cpc_checker #(
        .DATA_WIDTH    (DW),
        .FRACTION_BITS (FB),
        .ROTATION_STEPS(STEPS)
    ) conversion_check (
        .clk          (i_clk),
        .rst_n        (i_rst_n),
        .in_valid     (i_valid),
        .in_stall     (o_stall),
        .in_cmd       (i_cmd),
        .in_a         (i_a_in),
        .in_b         (i_b_in),
        .out_valid    (o_valid),
        .out_stall    (i_stall),
        .out_a        (o_a_out),
        .out_b        (o_b_out),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .words_checked(words_checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_cartesian_polar_converter_core: done, errors");
        $finish;
    end

    // output side: random stall, or a long hold-off when requested
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // offer one word, with optional idle cycles first; returns at the accept edge
    task automatic send_word(input logic cmd, input logic signed [DW-1:0] a,
                             input logic signed [DW-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_a_in  <= a;
        i_b_in  <= b;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_TO_POLAR) n_to_polar++;
        else n_to_cart++;
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        logic signed [DW-1:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0, 1: return r;
            2: return r >>> 10;
            3: return r >>> 20;
            4: return r >>> 28;
            default: begin
                case ($urandom_range(4))
                    0: return MAX_V;
                    1: return MIN_V;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // angles: wide random, within +-4 radians, or close to a multiple of pi/2
    function automatic logic signed [DW-1:0] pick_angle();
        logic signed [DW-1:0] r;
        int k;
        int jitter;
        r      = $urandom;
        k      = int'($urandom_range(16)) - 8;
        jitter = int'($urandom_range(4)) - 2;
        case ($urandom_range(3))
            0: return r;
            1: return r >>> 13;
            default: return HALF_PI_Q16 * k + jitter;
        endcase
    endfunction

    task automatic run_directed();
        send_word(CMD_TO_POLAR, 0, 0);              // zero vector
        send_word(CMD_TO_POLAR, ONE, 0);
        send_word(CMD_TO_POLAR, -ONE, 0);           // left half, y >= 0 -> +pi
        send_word(CMD_TO_POLAR, -ONE, -1);          // left half, y < 0 -> -pi
        send_word(CMD_TO_POLAR, 0, -ONE);
        send_word(CMD_TO_POLAR, 3 * ONE, 4 * ONE);
        send_word(CMD_TO_POLAR, MAX_V, MAX_V);      // radius saturates
        send_word(CMD_TO_POLAR, MIN_V, MIN_V);
        send_word(CMD_TO_POLAR, MIN_V, 0);
        send_word(CMD_TO_POLAR, 0, MAX_V);
        send_word(CMD_TO_POLAR, 1, -1);             // tiny vector
        send_word(CMD_TO_CART, ONE, 0);
        send_word(CMD_TO_CART, -ONE, HALF_PI_Q16 - 1);
        send_word(CMD_TO_CART, ONE, HALF_PI_Q16);   // just past pi/2: fold
        send_word(CMD_TO_CART, ONE, -HALF_PI_Q16);
        send_word(CMD_TO_CART, ONE, 205887);        // around pi
        send_word(CMD_TO_CART, ONE, 205888);
        send_word(CMD_TO_CART, ONE, -205888);
        send_word(CMD_TO_CART, 2 * ONE, 411775);    // about 2 pi
        send_word(CMD_TO_CART, MAX_V, MAX_V);
        send_word(CMD_TO_CART, MIN_V, MIN_V);
        send_word(CMD_TO_CART, MAX_V, 51472);       // pi/4 at full radius
        send_word(CMD_TO_CART, MIN_V, 0);
        send_word(CMD_TO_CART, 0, 12345);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
        logic cmd;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            if (with_hold && n == 50) hold_req = 1'b1;
            cmd = 1'($urandom_range(1));
            if (cmd == CMD_TO_POLAR) send_word(cmd, pick_value(), pick_value());
            else send_word(cmd, pick_value(), pick_angle());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd   <= CMD_TO_POLAR;
        i_a_in  <= '0;
        i_b_in  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(15, 64, 1'b0);
        run_phase(64, 15, 1'b0);
        run_phase(0, 0, 1'b1);      // includes the long output hold
        i_valid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d words sent (%0d to polar, %0d to Cartesian), %0d checked",
                 n_to_polar + n_to_cart, n_to_polar, n_to_cart, words_checked);
        $display("summary: idling on each side, no idling, and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_cartesian_polar_converter_core: done, clean");
        end else begin
            $display("tb_cartesian_polar_converter_core: done, errors");
        end
        $finish;
    end

endmodule
